### design/ttmb_pkg.sv
package ttmb_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_REQUIRED_TAPS    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_INTERVALS = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_US       = 2'd2;

    localparam logic [4:0]  REQUIRED_TAPS_RST    = 5'd4;
    localparam logic [4:0]  WINDOW_INTERVALS_RST = 5'd8;
    localparam logic [31:0] TIMEOUT_US_RST       = 32'd2000000;

    // interval and divider widths
    localparam int IVL_W      = 32;
    localparam int SUM_W      = IVL_W + 1;
    localparam int DEN_W      = SUM_W + 1;
    localparam int QUO_W      = 37;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    // 2 * 60e6 * 256 * 2, numerator before the rounding term
    localparam logic [QUO_W-1:0] BPM_NUM2 = 37'd61440000000;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CHECK = 12'b0000_0000_0010,
        ST_WRITE = 12'b0000_0000_0100,
        ST_TEST  = 12'b0000_0000_1000,
        ST_CAND  = 12'b0000_0001_0000,
        ST_LOAD  = 12'b0000_0010_0000,
        ST_INNER = 12'b0000_0100_0000,
        ST_DRAIN = 12'b0000_1000_0000,
        ST_SUM   = 12'b0001_0000_0000,
        ST_DIVI  = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } state_t;

endpackage

### design/tap_tempo_median_bpm.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    cmd, stamp_us
// out       output     out_valid / out_ready  taps_seen, restarted, bpm_valid, bpm_q8
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. A clear goes from idle straight to the output stage. A tap
// is checked, written to the interval RAM when valid, and tested against the
// required taps; a tap with a tempo then adds median selection over the n held
// intervals (one interval RAM read per cycle) and the bit-serial divider.
// Reset clears history and loads the register defaults. A result waiting on
// out_ready holds only the output stage; the next item can already be taken.
module tap_tempo_median_bpm #(
    parameter int MAX_INTERVALS = 16,
    parameter int STAMP_BITS    = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [STAMP_BITS-1:0] stamp_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            taps_seen,
    output logic                  restarted,
    output logic                  bpm_valid,
    output logic [31:0]           bpm_q8,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import ttmb_pkg::*;

    localparam int IDX_W  = (MAX_INTERVALS > 2) ? $clog2(MAX_INTERVALS) : 1;
    localparam int FILL_W = $clog2(MAX_INTERVALS + 1);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 2);
    localparam int CW     = (CNT_W > 5) ? CNT_W : 5;

    state_t state_reg, state_next;

    logic [4:0]            req_reg, req_next;
    logic [4:0]            win_reg, win_next;
    logic [31:0]           tmo_reg, tmo_next;

    logic                  have_prev_reg, have_prev_next;
    logic [STAMP_BITS-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  out_valid_reg, out_valid_next;

    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [IVL_W-1:0]      ival_reg, ival_next;
    logic [FILL_W-1:0]     ci_reg, ci_next;
    logic [FILL_W-1:0]     cj_reg, cj_next;
    logic [FILL_W-1:0]     lt_reg, lt_next;
    logic [FILL_W-1:0]     le_reg, le_next;
    logic                  pend_reg, pend_next;
    logic [IVL_W-1:0]      cand_reg, cand_next;
    logic [IVL_W-1:0]      lo_reg, lo_next;
    logic [IVL_W-1:0]      hi_reg, hi_next;
    logic [SUM_W-1:0]      s_reg, s_next;
    logic [QUO_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [4:0]            res_taps_reg, res_taps_next;
    logic                  res_rst_reg, res_rst_next;
    logic                  res_vld_reg, res_vld_next;
    logic [31:0]           res_bpm_reg, res_bpm_next;
    logic [4:0]            o_taps_reg, o_taps_next;
    logic                  o_rst_reg, o_rst_next;
    logic                  o_vld_reg, o_vld_next;
    logic [31:0]           o_bpm_reg, o_bpm_next;

    logic [IVL_W-1:0]      ring_mem [MAX_INTERVALS];
    logic [IVL_W-1:0]      rd_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_en;

    // effective configuration
    logic [CW-1:0]         req_ext, r_lo, r_eff;
    logic [CW-1:0]         win_ext, w_lo, w_clip;
    logic [FILL_W-1:0]     w_eff;
    logic [31:0]           limit;

    logic [STAMP_BITS-1:0] diff;
    logic                  bad_ivl;
    logic [FILL_W-1:0]     drop;
    logic [FILL_W:0]       head_sum;
    logic [CW-1:0]         taps;
    logic [FILL_W-1:0]     n_last, k_hi, k_lo;
    logic                  cmp_en;
    logic [FILL_W-1:0]     lt_new, le_new;
    logic [DEN_W:0]        rem_sh;
    logic                  q_bit;
    logic [QUO_W-1:0]      quo;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [FILL_W-1:0] ofs);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(base) + (FILL_W+1)'(ofs);
        if (sum >= (FILL_W+1)'(MAX_INTERVALS))
            sum = sum - (FILL_W+1)'(MAX_INTERVALS);
        return IDX_W'(sum);
    endfunction

    assign req_ext = CW'(req_reg);
    assign r_lo    = (req_ext < CW'(3)) ? CW'(3) : req_ext;
    assign r_eff   = (r_lo > CW'(MAX_INTERVALS + 1)) ? CW'(MAX_INTERVALS + 1) : r_lo;
    assign win_ext = CW'(win_reg);
    assign w_lo    = (win_ext < r_eff - CW'(1)) ? r_eff - CW'(1) : win_ext;
    assign w_clip  = (w_lo > CW'(MAX_INTERVALS)) ? CW'(MAX_INTERVALS) : w_lo;
    assign w_eff   = FILL_W'(w_clip);
    assign limit   = (tmo_reg == 32'd0) ? 32'd1 : tmo_reg;

    assign diff    = stamp_reg - prev_reg;
    assign bad_ivl = (stamp_reg <= prev_reg) || (diff > STAMP_BITS'(limit));
    assign drop    = fill_reg - w_eff + FILL_W'(1);
    assign head_sum = (FILL_W+1)'(head_reg) + (FILL_W+1)'(drop);
    assign taps    = CW'(fill_reg) + CW'(1);

    assign n_last  = fill_reg - FILL_W'(1);
    assign k_hi    = fill_reg >> 1;
    assign k_lo    = fill_reg[0] ? k_hi : k_hi - FILL_W'(1);

    assign cmp_en  = ((state_reg == ST_INNER) && pend_reg) || (state_reg == ST_DRAIN);
    assign lt_new  = lt_reg + FILL_W'(cmp_en && (rd_reg < cand_reg));
    assign le_new  = le_reg + FILL_W'(cmp_en && (rd_reg <= cand_reg));

    assign rem_sh  = {rem_reg, num_reg[QUO_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});
    assign quo     = {num_reg[QUO_W-2:0], q_bit};

    assign rd_addr = (state_reg == ST_CAND) ? phys(head_reg, ci_reg) : phys(head_reg, cj_reg);
    assign wr_addr = phys(head_reg, fill_reg);
    assign wr_en   = (state_reg == ST_WRITE);

    // interval RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        rd_reg <= ring_mem[rd_addr];
        if (wr_en)
        begin
            ring_mem[wr_addr] <= ival_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        win_next       = win_reg;
        tmo_next       = tmo_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        stamp_next     = stamp_reg;
        ival_next      = ival_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        lt_next        = lt_reg;
        le_next        = le_reg;
        pend_next      = (state_reg == ST_INNER);
        cand_next      = cand_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        s_next         = s_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        res_taps_next  = res_taps_reg;
        res_rst_next   = res_rst_reg;
        res_vld_next   = res_vld_reg;
        res_bpm_next   = res_bpm_reg;
        o_taps_next    = o_taps_reg;
        o_rst_next     = o_rst_reg;
        o_vld_next     = o_vld_reg;
        o_bpm_next     = o_bpm_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REQUIRED_TAPS:    req_next = cfg_data[4:0];
                CFG_WINDOW_INTERVALS: win_next = cfg_data[4:0];
                CFG_TIMEOUT_US:       tmo_next = cfg_data;
                default:              ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd)
                    begin
                        have_prev_next = 1'b0;
                        head_next      = '0;
                        fill_next      = '0;
                        res_taps_next  = '0;
                        res_rst_next   = 1'b0;
                        res_vld_next   = 1'b0;
                        res_bpm_next   = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        stamp_next = stamp_us;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                have_prev_next = 1'b1;
                prev_next      = stamp_reg;
                res_rst_next   = 1'b0;
                res_bpm_next   = '0;
                state_next     = ST_TEST;
                if (have_prev_reg)
                begin
                    if (bad_ivl)
                    begin
                        head_next    = '0;
                        fill_next    = '0;
                        res_rst_next = 1'b1;
                    end
                    else
                    begin
                        ival_next  = diff[IVL_W-1:0];
                        state_next = ST_WRITE;
                        // window full or shrunk: drop oldest entries
                        if (fill_reg >= w_eff)
                        begin
                            if (head_sum >= (FILL_W+1)'(MAX_INTERVALS))
                                head_next = IDX_W'(head_sum - (FILL_W+1)'(MAX_INTERVALS));
                            else
                                head_next = IDX_W'(head_sum);
                            fill_next = w_eff - FILL_W'(1);
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                fill_next  = fill_reg + FILL_W'(1);
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                res_taps_next = 5'(taps);
                ci_next       = '0;
                if (taps >= r_eff)
                begin
                    res_vld_next = 1'b1;
                    state_next   = ST_CAND;
                end
                else
                begin
                    res_vld_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_CAND:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cand_next  = rd_reg;
                lt_next    = '0;
                le_next    = '0;
                cj_next    = '0;
                state_next = ST_INNER;
            end
            ST_INNER:
            begin
                lt_next = lt_new;
                le_next = le_new;
                if (cj_reg == n_last)
                    state_next = ST_DRAIN;
                else
                    cj_next = cj_reg + FILL_W'(1);
            end
            ST_DRAIN:
            begin
                // candidate holds sorted position k when lt <= k < le
                if ((lt_new <= k_lo) && (k_lo < le_new))
                    lo_next = cand_reg;
                if ((lt_new <= k_hi) && (k_hi < le_new))
                    hi_next = cand_reg;
                if (ci_reg == n_last)
                    state_next = ST_SUM;
                else
                begin
                    ci_next    = ci_reg + FILL_W'(1);
                    state_next = ST_CAND;
                end
            end
            ST_SUM:
            begin
                s_next     = SUM_W'(lo_reg) + SUM_W'(hi_reg);
                state_next = ST_DIVI;
            end
            ST_DIVI:
            begin
                num_next  = BPM_NUM2 + QUO_W'(s_reg);
                den_next  = {s_reg, 1'b0};
                rem_next  = '0;
                dcnt_next = '0;
                if (s_reg == '0)
                begin
                    res_bpm_next = '0;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (q_bit)
                    rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                else
                    rem_next = rem_sh[DEN_W-1:0];
                num_next  = quo;
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    if (quo[QUO_W-1:32] != '0)
                        res_bpm_next = '1;
                    else
                        res_bpm_next = quo[31:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_taps_next    = res_taps_reg;
                    o_rst_next     = res_rst_reg;
                    o_vld_next     = res_vld_reg;
                    o_bpm_next     = res_bpm_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= REQUIRED_TAPS_RST;
            win_reg       <= WINDOW_INTERVALS_RST;
            tmo_reg       <= TIMEOUT_US_RST;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            win_reg       <= win_next;
            tmo_reg       <= tmo_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg    <= stamp_next;
        ival_reg     <= ival_next;
        ci_reg       <= ci_next;
        cj_reg       <= cj_next;
        lt_reg       <= lt_next;
        le_reg       <= le_next;
        cand_reg     <= cand_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        s_reg        <= s_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        res_taps_reg <= res_taps_next;
        res_rst_reg  <= res_rst_next;
        res_vld_reg  <= res_vld_next;
        res_bpm_reg  <= res_bpm_next;
        o_taps_reg   <= o_taps_next;
        o_rst_reg    <= o_rst_next;
        o_vld_reg    <= o_vld_next;
        o_bpm_reg    <= o_bpm_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign taps_seen = o_taps_reg;
    assign restarted = o_rst_reg;
    assign bpm_valid = o_vld_reg;
    assign bpm_q8    = o_bpm_reg;

endmodule
